FILE: rtl/core/bba_pkg.sv
package bba_pkg;

  localparam int HEAP_BYTES  = 16384;
  localparam int BLOCK_BYTES = 32;
  localparam int ENTRIES     = 512;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LVL_W   = IDX_W + 1;
  localparam int ENTRY_W = 16;
  localparam int OFF_W   = $clog2(BLOCK_BYTES);

  localparam logic [31:0] HEAP_BASE_RST = 32'h2000_1000;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_REJECT = 2'd2,
    ST_EDGE   = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

endpackage

FILE: rtl/core/buddy_block_allocator_core.sv
// An allocate scans the candidate blocks, one table read per candidate (up to
// 512), then marks the levels above the chosen block; a free walks up the merge
// levels one at a time. One word is in flight at a time; the single read port
// of the control table sets the pace of both walks.
// Reset: synchronous, active low. After reset the control table is cleared in
// a pass over all 512 entries, entry 0 set to the whole heap; in_stall stays high.
module buddy_block_allocator_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_operation,
  input  logic [15:0]             in_request_size,
  input  logic [31:0]             in_block_address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bba_pkg::status_t        out_status,
  output logic [31:0]             out_result_address,
  input  logic                    cfg_wr_en,
  input  logic [31:0]             cfg_wr_data
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_SCAN, A_SET, A_MRD, A_MWR,
    F_LD, F_EVAL, F_BUD, F_MRG, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [31:0]          heap_base_r, heap_base_nxt;
  logic                 op_r, op_nxt;
  logic [15:0]          size_r, size_nxt;
  logic [31:0]          addr_r, addr_nxt;
  logic [LVL_W-1:0]     l_r, l_nxt;
  logic [LVL_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     buddy_r, buddy_nxt;
  logic [LVL_W-1:0]     h_r, h_nxt;
  logic [ENTRY_W-1:0]   val_r, val_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [31:0]          res_addr_r, res_addr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [31:0]          out_addr_r, out_addr_nxt;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

  logic [ENTRY_W-1:0]   lbytes;
  logic [LVL_W-1:0]     lsel;
  logic [31:0]          off;
  logic [ENTRY_W-OFF_W-1:0] blocks;
  logic                 is_right;
  logic [IDX_W:0]       left_sum;
  logic [IDX_W-1:0]     buddy_idx;
  logic [IDX_W-1:0]     hb, mid;
  logic [ENTRY_W-1:0]   merged;

  bba_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lbytes   = {1'b0, l_r, {OFF_W{1'b0}}};
  assign off      = addr_r - heap_base_r;
  assign blocks   = val_r[ENTRY_W-1:OFF_W];
  // Block sizes are always powers of two, so the parity of idx / blocks is one bit.
  assign is_right = |(idx_r & blocks[IDX_W-1:0]);
  assign left_sum = {1'b0, idx_r} + blocks[IDX_W:0];
  assign buddy_idx = is_right ? (idx_r - blocks[IDX_W-1:0]) : left_sum[IDX_W-1:0];
  assign hb       = h_r[IDX_W-1:0];
  assign mid      = (idx_r & ~(hb | (hb - 1'b1))) | hb;
  assign merged   = {val_r[ENTRY_W-2:OFF_W], {(OFF_W+1){1'b0}}};

  // Smallest power-of-two block count whose bytes cover the request.
  always_comb begin
    lsel = '0;
    for (int k = LVL_W - 1; k >= 0; k--) begin
      if (size_r <= ENTRY_W'(BLOCK_BYTES << k)) begin
        lsel = LVL_W'(1) << k;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    heap_base_nxt  = cfg_wr_en ? cfg_wr_data : heap_base_r;
    op_nxt         = op_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    l_nxt          = l_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_pend_nxt    = rd_pend_r;
    rd_idx_nxt     = rd_idx_r;
    idx_nxt        = idx_r;
    buddy_nxt      = buddy_r;
    h_nxt          = h_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_valid_nxt  = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = (clr_cnt_r == '0) ? ENTRY_W'(HEAP_BYTES) : '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          size_nxt  = in_request_size;
          addr_nxt  = in_block_address;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_addr_nxt = '0;
        if (op_r == OP_ALLOC) begin
          if (size_r < 16'(BLOCK_BYTES) || size_r > 16'(HEAP_BYTES)) begin
            res_status_nxt = ST_REJECT;
            state_nxt      = S_DONE;
          end else begin
            l_nxt        = lsel;
            scan_cnt_nxt = '0;
            rd_pend_nxt  = 1'b0;
            state_nxt    = S_SCAN;
          end
        end else begin
          if (addr_r < heap_base_r || off > 32'(HEAP_BYTES - BLOCK_BYTES)) begin
            res_status_nxt = ST_REJECT;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt   = off[OFF_W +: IDX_W];
            ram_re    = 1'b1;
            ram_raddr = off[OFF_W +: IDX_W];
            state_nxt = F_LD;
          end
        end
      end
      S_SCAN: begin
        // Reads are issued one candidate a cycle; each check works on the registered data of the read before it.
        if (rd_pend_r && !ram_rdata[0] && ram_rdata >= lbytes) begin
          idx_nxt   = rd_idx_r;
          state_nxt = A_SET;
        end else if (scan_cnt_r[IDX_W] && !rd_pend_r) begin
          res_status_nxt = ST_NOFIT;
          state_nxt      = S_DONE;
        end else if (!scan_cnt_r[IDX_W]) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_cnt_r[IDX_W-1:0];
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + l_r;
        end else begin
          rd_pend_nxt = 1'b0;
        end
      end
      A_SET: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = lbytes | ENTRY_W'(1);
        h_nxt     = l_r;
        state_nxt = A_MRD;
      end
      A_MRD: begin
        if (h_r[IDX_W]) begin
          res_status_nxt = ST_DONE;
          res_addr_nxt   = heap_base_r + {{(32-IDX_W-OFF_W){1'b0}}, idx_r, {OFF_W{1'b0}}};
          state_nxt      = S_DONE;
        end else if (|(idx_r & hb)) begin
          h_nxt = h_r << 1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = mid;
          state_nxt = A_MWR;
        end
      end
      A_MWR: begin
        if (!ram_rdata[0]) begin
          ram_we    = 1'b1;
          ram_waddr = mid;
          ram_wdata = {1'b0, h_r, {OFF_W{1'b0}}};
        end
        h_nxt     = h_r << 1;
        state_nxt = A_MRD;
      end
      F_LD: begin
        val_nxt   = ram_rdata;
        state_nxt = F_EVAL;
      end
      F_EVAL: begin
        if (blocks == '0) begin
          res_status_nxt = ST_REJECT;
          state_nxt      = S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = {val_r[ENTRY_W-1:OFF_W], {OFF_W{1'b0}}};
          if ((!is_right && left_sum >= (IDX_W+1)'(ENTRIES)) ||
              (is_right && {2'b0, idx_r} < blocks)) begin
            res_status_nxt = ST_EDGE;
            state_nxt      = S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = buddy_idx;
            buddy_nxt = buddy_idx;
            state_nxt = F_BUD;
          end
        end
      end
      F_BUD: begin
        if (ram_rdata[0] || ram_rdata[ENTRY_W-1:OFF_W] != blocks) begin
          res_status_nxt = ST_DONE;
          res_addr_nxt   = addr_r;
          state_nxt      = S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = is_right ? idx_r : buddy_r;
          ram_wdata = '0;
          state_nxt = F_MRG;
        end
      end
      F_MRG: begin
        ram_we    = 1'b1;
        ram_waddr = is_right ? buddy_r : idx_r;
        ram_wdata = merged;
        if (is_right) begin
          idx_nxt = buddy_r;
        end
        val_nxt   = merged;
        state_nxt = F_EVAL;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      heap_base_r <= HEAP_BASE_RST;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      heap_base_r <= heap_base_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
    op_r         <= op_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    l_r          <= l_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    idx_r        <= idx_nxt;
    buddy_r      <= buddy_nxt;
    h_r          <= h_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("table read and write hit the same entry");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_NOFIT || out_status_r == ST_REJECT ||
                    out_status_r == ST_EDGE) |-> out_addr_r == '0)
    else $error("failed word carries a nonzero address");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DEC)
    else $error("accepted word not decoded");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word loaded outside the done state");

endmodule

FILE: rtl/core/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sim/tb_buddy_block_allocator_core.sv
`timescale 1ns / 100ps

module tb_buddy_block_allocator_core;
  import bba_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [15:0] size;
    logic [31:0] addr;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] addr;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [15:0] in_request_size;
  logic [31:0] in_block_address;
  logic        out_valid;
  logic        out_stall;
  status_t     out_status;
  logic [31:0] out_result_address;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  buddy_block_allocator_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_request_size    (in_request_size),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  request_t    pending_words[$];
  answer_t     expected_answers[$];
  logic [31:0] live_blocks[$];
  logic [31:0] table_model[ENTRIES];
  logic [31:0] base_model;
  int          mismatches;
  int          accepted;
  bit          quiet_phase;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("buddy_block_allocator_core: mismatch");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR word %0d: %s got %h expected %h", accepted, what, got, want);
    mismatches++;
  endtask

  function automatic bit search_tree(input logic [31:0] size, input int lo, input int hi,
                                     output int found);
    int span;
    int half;
    int mid;
    span = hi - lo + 1;
    half = span / 2;
    mid = lo + half;
    found = 0;
    if (half > 0 && size <= half * BLOCK_BYTES) begin
      if (!search_tree(size, lo, mid - 1, found))
        return search_tree(size, mid, hi, found);
      if (table_model[mid][0] == 1'b0)
        table_model[mid] = half * BLOCK_BYTES;
      return 1'b1;
    end
    if (table_model[lo][0] == 1'b1) return 1'b0;
    if (table_model[lo] < span * BLOCK_BYTES) return 1'b0;
    table_model[lo] = span * BLOCK_BYTES + 1;
    found = lo;
    return 1'b1;
  endfunction

  function automatic status_t merge_up(input int idx);
    int          blocks;
    logic [31:0] mine;
    logic [31:0] pal;
    for (int g = 0; g < 40; g++) begin
      blocks = table_model[idx] / BLOCK_BYTES;
      mine = blocks * BLOCK_BYTES;
      if (blocks == 0) return ST_REJECT;
      table_model[idx] = mine;
      if (((idx / blocks) & 1) == 0) begin
        if (idx + blocks >= ENTRIES) return ST_EDGE;
        pal = table_model[idx + blocks];
        if (pal[0] || (pal / BLOCK_BYTES) * BLOCK_BYTES != mine) return ST_DONE;
        table_model[idx + blocks] = 0;
        table_model[idx] = mine * 2;
      end else begin
        if (idx < blocks) return ST_EDGE;
        pal = table_model[idx - blocks];
        if (pal[0] || (pal / BLOCK_BYTES) * BLOCK_BYTES != mine) return ST_DONE;
        table_model[idx] = 0;
        table_model[idx - blocks] = mine * 2;
        idx -= blocks;
      end
    end
    return ST_DONE;
  endfunction

  function automatic answer_t predict_answer(input request_t r);
    answer_t     a;
    int          idx;
    logic [32:0] off;
    a.status = ST_DONE;
    a.addr = '0;
    if (r.op == OP_ALLOC) begin
      if (r.size < BLOCK_BYTES || r.size > HEAP_BYTES)
        a.status = ST_REJECT;
      else if (search_tree(r.size, 0, ENTRIES - 1, idx))
        a.addr = base_model + idx * BLOCK_BYTES;
      else
        a.status = ST_NOFIT;
    end else if (r.addr < base_model) begin
      a.status = ST_REJECT;
    end else begin
      off = {1'b0, r.addr} - {1'b0, base_model};
      if (off > HEAP_BYTES - BLOCK_BYTES)
        a.status = ST_REJECT;
      else begin
        a.status = merge_up(int'(off / BLOCK_BYTES));
        if (a.status == ST_DONE) a.addr = r.addr;
      end
    end
    return a;
  endfunction

  function automatic request_t make_word(input op_t op, input logic [15:0] size,
                                        input logic [31:0] addr);
    request_t r;
    r.op = op;
    r.size = size;
    r.addr = addr;
    return r;
  endfunction

  // Driver: a held word stays put until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(predict_answer({op_t'(in_operation), in_request_size,
                                                   in_block_address}));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && (quiet_phase || $urandom_range(99) >= 20)) begin
          request_t r;
          r = pending_words.pop_front();
          in_valid <= 1'b1;
          in_operation <= r.op;
          in_request_size <= r.size;
          in_block_address <= r.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report("unexpected word status", 32'(out_status), '0);
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (out_status != e.status)
            report("status", 32'(out_status), 32'(e.status));
          if (out_result_address != e.addr) report("address", out_result_address, e.addr);
          // Keep addresses of live blocks so that later frees hit real blocks.
          if (e.status == ST_DONE && e.addr != 0 && $urandom_range(1))
            live_blocks.push_back(e.addr);
        end
      end
      out_stall <= !quiet_phase && $urandom_range(99) < 20;
    end
  end

  task automatic drain();
    int waited;
    waited = 0;
    while ((pending_words.size() > 0 || in_valid || expected_answers.size() > 0)
           && waited < 2000000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
  endtask

  task automatic write_base(input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_model = value;
    live_blocks.delete();
  endtask

  task automatic random_phase(input int count);
    logic [31:0] a;
    logic [15:0] s;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        s = (pick < 5) ? 16'($urandom) : 16'($urandom_range(HEAP_BYTES / 4, BLOCK_BYTES));
        if (pick == 6) s = 16'(BLOCK_BYTES << $urandom_range(9));
        pending_words.push_back(make_word(OP_ALLOC, s, 32'($urandom)));
      end else if (pick < 85 && live_blocks.size() > 0) begin
        a = live_blocks[$urandom_range(live_blocks.size() - 1)];
        pending_words.push_back(make_word(OP_FREE, 16'($urandom), a));
      end else if (pick < 93) begin
        a = base_model + $urandom_range(HEAP_BYTES / BLOCK_BYTES - 1) * BLOCK_BYTES
            + ($urandom_range(3) == 0 ? $urandom_range(BLOCK_BYTES - 1) : 0);
        pending_words.push_back(make_word(OP_FREE, 16'($urandom), a));
      end else begin
        pending_words.push_back(make_word(OP_FREE, 16'($urandom), 32'($urandom)));
      end
      // Let the queue drain gradually so frees can follow allocations.
      while (pending_words.size() > 4) @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_request_size = '0;
    in_block_address = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    mismatches = 0;
    accepted = 0;
    quiet_phase = 1'b0;
    base_model = HEAP_BASE_RST;
    for (int i = 0; i < ENTRIES; i++) table_model[i] = 0;
    table_model[0] = HEAP_BYTES;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset base: extremes, rejects and edge cases.
    pending_words.push_back(make_word(OP_ALLOC, 16'd0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_ALLOC, 16'd31, 32'h0));
    pending_words.push_back(make_word(OP_ALLOC, 16'hFFFF, 32'h0));
    pending_words.push_back(make_word(OP_ALLOC, 16'd16385, 32'h0));
    pending_words.push_back(make_word(OP_ALLOC, 16'd16384, 32'h0));
    pending_words.push_back(make_word(OP_ALLOC, 16'd32, 32'h0));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST));
    pending_words.push_back(make_word(OP_ALLOC, 16'd32, 32'h0));
    pending_words.push_back(make_word(OP_ALLOC, 16'd33, 32'h0));
    pending_words.push_back(make_word(OP_ALLOC, 16'd8192, 32'h0));
    pending_words.push_back(make_word(OP_ALLOC, 16'd8192, 32'h0));
    pending_words.push_back(make_word(OP_FREE, 16'hFFFF, HEAP_BASE_RST + 32'h2000));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST + 32'h20));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST + 32'h40));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST - 1));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST + 32'h3FE0));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST + 32'h3FFF));
    pending_words.push_back(make_word(OP_FREE, 16'd0, HEAP_BASE_RST + 32'h4000));
    pending_words.push_back(make_word(OP_FREE, 16'd0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_FREE, 16'd0, 32'h0));
    drain();

    random_phase(250);
    drain();
    write_base(32'h0000_0000);
    random_phase(150);
    drain();
    write_base(32'hFFFF_C000);
    pending_words.push_back(make_word(OP_FREE, 16'd0, 32'hFFFF_FFE0));
    random_phase(100);
    drain();
    write_base(32'($urandom));
    quiet_phase = 1'b1;
    random_phase(120);
    drain();
    quiet_phase = 1'b0;
    write_base(HEAP_BASE_RST);
    random_phase(180);
    drain();

    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("buddy_block_allocator_core: match");
    end else begin
      $display("buddy_block_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
